// ===== src/bvfg_pkg.sv =====
// Shared types, constants and helper functions for the battery voltage
// filter and fuel gauge. No dependencies; every other file but bvfg_ram uses it.
`default_nettype none

package bvfg_pkg;

    localparam int ADC_W  = 12;
    localparam int MV_W   = 13;
    localparam int TIME_W = 32;
    localparam int PCT_W  = 7;

    localparam int WIN_DEPTH    = 16;
    localparam int WIN_AW       = $clog2(WIN_DEPTH);
    localparam int WIN_TOTAL_W  = MV_W + WIN_AW;
    localparam int WIN_RECIP_K  = WIN_TOTAL_W + WIN_AW;
    localparam int WIN_RECIP_W  = WIN_RECIP_K - WIN_AW + 2;
    localparam longint unsigned WIN_RECIP =
        ((64'd1 << WIN_RECIP_K) + WIN_DEPTH - 1) / WIN_DEPTH;

    localparam int DECIMATION = 4;
    localparam int DEC_W      = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    localparam int ALPHA_W   = 9;
    localparam int JUMP_W    = 13;
    localparam int STEADY_W  = 16;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE        = 9'd256;
    localparam logic [MV_W-1:0]     DEADBAND_MV      = 13'd5;
    localparam logic [MV_W-1:0]     CAL_MIN_DELTA_MV = 13'd50;
    localparam logic [STEADY_W-1:0] STEADY_MAX       = 16'hFFFF;
    localparam logic [PCT_W-1:0]    PCT_FULL         = 7'd100;
    localparam logic [PCT_W-1:0]    PCT_EMPTY        = 7'd0;

    localparam logic [ALPHA_W-1:0]  RST_EMA_ALPHA    = 9'd26;
    localparam logic [JUMP_W-1:0]   RST_MAX_JUMP     = 13'd100;
    localparam logic [STEADY_W-1:0] RST_STABLE_STEPS = 16'd10;
    localparam logic [TIME_W-1:0]   RST_CAL_INTERVAL = 32'd60000;
    localparam logic [MV_W-1:0]     RST_CAL_LOW      = 13'd2500;
    localparam logic [MV_W-1:0]     RST_CAL_HIGH     = 13'd4500;
    localparam logic [MV_W-1:0]     RST_SAVED_MIN    = 13'd2800;
    localparam logic [MV_W-1:0]     RST_SAVED_MAX    = 13'd4200;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_ALPHA,
        CFG_MAX_JUMP,
        CFG_STABLE_STEPS,
        CFG_CAL_INTERVAL,
        CFG_CAL_LOW,
        CFG_CAL_HIGH,
        CFG_SAVED_MIN,
        CFG_SAVED_MAX
    } cfg_idx_t;

    localparam logic [MV_W-1:0] LVL_MV [8] = '{
        13'd4200, 13'd4000, 13'd3800, 13'd3600,
        13'd3400, 13'd3200, 13'd3000, 13'd2800
    };
    localparam logic [PCT_W-1:0] LVL_PCT [8] = '{
        7'd100, 7'd90, 7'd80, 7'd60, 7'd45, 7'd30, 7'd15, 7'd0
    };
    // segment slope as percent per 200 mV, scaled by 2^13 / 200, rounded up
    localparam logic [9:0] LVL_SLOPE [8] = '{
        10'd410, 10'd410, 10'd820, 10'd615, 10'd615, 10'd615, 10'd615, 10'd0
    };
    localparam int SLOPE_SHIFT = 13;

    typedef struct packed {
        logic [ADC_W-1:0]  adc_mv_0;
        logic [ADC_W-1:0]  adc_mv_1;
        logic [ADC_W-1:0]  adc_mv_2;
        logic [ADC_W-1:0]  adc_mv_3;
        logic              charge_pin_low;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [MV_W-1:0]  stable_mv;
        logic [PCT_W-1:0] percent;
        logic             charging;
        logic             report_changed;
        logic [MV_W-1:0]  window_mv;
        logic [MV_W-1:0]  ema_mv;
        logic [MV_W-1:0]  range_min_mv;
        logic [MV_W-1:0]  range_max_mv;
        logic             save_request;
    } result_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]  ema_alpha_q8;
        logic [JUMP_W-1:0]   max_jump_mv;
        logic [STEADY_W-1:0] stable_steps_needed;
        logic [TIME_W-1:0]   calibration_interval_ms;
        logic [MV_W-1:0]     cal_low_limit_mv;
        logic [MV_W-1:0]     cal_high_limit_mv;
        logic [MV_W-1:0]     saved_min_mv;
        logic [MV_W-1:0]     saved_max_mv;
    } cfg_t;

    typedef struct packed {
        logic            wr_min;
        logic            wr_max;
        logic [MV_W-1:0] mv;
    } cfg_wr_t;

    typedef struct packed {
        logic              first;
        logic              charging;
        logic [TIME_W-1:0] now_ms;
        logic [MV_W-1:0]   window_mv;
    } win_t;

    typedef struct packed {
        logic              first;
        logic              charging;
        logic [TIME_W-1:0] now_ms;
        logic [MV_W-1:0]   window_mv;
        logic [MV_W-1:0]   ema_mv;
    } ema_t;

    typedef struct packed {
        logic [MV_W-1:0] stable_mv;
        logic            charging;
        logic [MV_W-1:0] window_mv;
        logic [MV_W-1:0] ema_mv;
        logic [MV_W-1:0] range_min_mv;
        logic [MV_W-1:0] range_max_mv;
        logic            save_request;
    } trk_t;

    function automatic logic [MV_W-1:0] absdiff_mv(input logic [MV_W-1:0] a,
                                                    input logic [MV_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [PCT_W-1:0] gauge_pct(input logic [MV_W-1:0] v);
        logic [2:0]      seg;
        logic [2:0]      seg_lo;
        logic [MV_W-1:0] d_mv;
        logic [17:0]     prod;
        logic [PCT_W-1:0] res;
        seg = 3'd0;
        for (int i = 0; i < 7; i++) begin
            if (v <= LVL_MV[i] && v > LVL_MV[i+1]) begin
                seg = 3'(i);
            end
        end
        seg_lo = 3'(seg + 3'd1);
        d_mv = v - LVL_MV[seg_lo];
        prod = 18'(d_mv[7:0]) * 18'(LVL_SLOPE[seg]);
        if (v >= LVL_MV[0]) begin
            res = PCT_FULL;
        end else if (v <= LVL_MV[7]) begin
            res = PCT_EMPTY;
        end else begin
            res = LVL_PCT[seg_lo] + PCT_W'(prod >> SLOPE_SHIFT);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/bvfg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bvfg_ram #(
    parameter int WIDTH = 13,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bvfg_window.sv =====
// Window stage: doubled four-reading average, ring-window moving average.
// Depends on bvfg_pkg and bvfg_ram.
`default_nettype none

module bvfg_window (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire bvfg_pkg::sample_t s0,
    output bvfg_pkg::win_t        s1
);

    localparam int TW = bvfg_pkg::WIN_TOTAL_W;
    localparam int PW = TW + bvfg_pkg::WIN_RECIP_W;
    localparam logic [bvfg_pkg::WIN_AW-1:0] POS_LAST =
        bvfg_pkg::WIN_AW'(bvfg_pkg::WIN_DEPTH - 1);

    logic                          primed_reg;
    logic                          lap_reg, lap_next;
    logic [bvfg_pkg::WIN_AW-1:0]   pos_reg, pos_next;
    logic [TW-1:0]                 total_reg, total_next;
    logic [bvfg_pkg::MV_W-1:0]     first_reg;
    logic [bvfg_pkg::MV_W-1:0]     old_mv, rd_mv, v_mv, avg_mv;
    logic [bvfg_pkg::ADC_W+1:0]    sum;
    logic [PW-1:0]                 prod;
    bvfg_pkg::win_t                s1_reg;

    always_comb
    begin
        sum = (bvfg_pkg::ADC_W+2)'(s0.adc_mv_0) + (bvfg_pkg::ADC_W+2)'(s0.adc_mv_1)
            + (bvfg_pkg::ADC_W+2)'(s0.adc_mv_2) + (bvfg_pkg::ADC_W+2)'(s0.adc_mv_3);
        v_mv = {sum[bvfg_pkg::ADC_W+1:2], 1'b0};
        old_mv = lap_reg ? rd_mv : first_reg;
        if (primed_reg)
        begin
            total_next = (total_reg - TW'(old_mv)) + TW'(v_mv);
            pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
            lap_next = lap_reg | (pos_reg == POS_LAST);
        end
        else
        begin
            total_next = TW'(v_mv) * TW'(bvfg_pkg::WIN_DEPTH);
            pos_next = pos_reg;
            lap_next = 1'b0;
        end
        prod = PW'(total_next) * PW'(bvfg_pkg::WIN_RECIP);
        avg_mv = prod[bvfg_pkg::WIN_RECIP_K +: bvfg_pkg::MV_W];
    end

    bvfg_ram #(
        .WIDTH (bvfg_pkg::MV_W),
        .DEPTH (bvfg_pkg::WIN_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load && primed_reg),
        .waddr (pos_reg),
        .wdata (v_mv),
        .re    (load),
        .raddr (pos_next),
        .rdata (rd_mv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            lap_reg    <= 1'b0;
            pos_reg    <= '0;
            total_reg  <= '0;
        end
        else if (load)
        begin
            primed_reg <= 1'b1;
            lap_reg    <= lap_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (!primed_reg)
            begin
                first_reg <= v_mv;
            end
            s1_reg.first     <= !primed_reg;
            s1_reg.charging  <= s0.charge_pin_low;
            s1_reg.now_ms    <= s0.now_ms;
            s1_reg.window_mv <= avg_mv;
        end
    end

    assign s1 = s1_reg;

endmodule

`default_nettype wire

// ===== src/bvfg_ema.sv =====
// EMA stage: Q1.8 exponential average with weight halved on large jumps.
// Depends on bvfg_pkg.
`default_nettype none

module bvfg_ema (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire bvfg_pkg::cfg_t cfg,
    input  wire bvfg_pkg::win_t s1,
    output bvfg_pkg::ema_t      s2
);

    logic [bvfg_pkg::MV_W-1:0]    ema_reg, ema_base, ema_new;
    logic [bvfg_pkg::ALPHA_W-1:0] w_sat, w_eff;
    logic signed [bvfg_pkg::MV_W:0]      diff, absd, ema_sum;
    logic signed [bvfg_pkg::ALPHA_W:0]   w_s;
    logic signed [23:0]                  prod, step;
    bvfg_pkg::ema_t               s2_reg;

    always_comb
    begin
        ema_base = s1.first ? s1.window_mv : ema_reg;
        w_sat = (cfg.ema_alpha_q8 > bvfg_pkg::ALPHA_ONE) ? bvfg_pkg::ALPHA_ONE
                                                         : cfg.ema_alpha_q8;
        diff = $signed({1'b0, s1.window_mv}) - $signed({1'b0, ema_base});
        absd = (diff < 0) ? -diff : diff;
        w_eff = (absd[bvfg_pkg::MV_W-1:0] > cfg.max_jump_mv) ? (w_sat >> 1) : w_sat;
        w_s = $signed({1'b0, w_eff});
        prod = w_s * diff;
        step = prod >>> 8;
        ema_sum = $signed({1'b0, ema_base}) + step[bvfg_pkg::MV_W:0];
        ema_new = ema_sum[bvfg_pkg::MV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ema_reg <= '0;
        end
        else if (load)
        begin
            ema_reg <= ema_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg.first     <= s1.first;
            s2_reg.charging  <= s1.charging;
            s2_reg.now_ms    <= s1.now_ms;
            s2_reg.window_mv <= s1.window_mv;
            s2_reg.ema_mv    <= ema_new;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

// ===== src/bvfg_track.sv =====
// Decimator with deadband and min/max range calibration tracker.
// Depends on bvfg_pkg.
`default_nettype none

module bvfg_track (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire bvfg_pkg::cfg_t    cfg,
    input  wire bvfg_pkg::cfg_wr_t cfg_wr,
    input  wire bvfg_pkg::ema_t    s2,
    output bvfg_pkg::trk_t         s3
);

    logic [bvfg_pkg::DEC_W-1:0]    dec_cnt_reg, dec_cnt_next;
    logic [bvfg_pkg::MV_W-1:0]     held_reg, held_base, held_next;
    logic [bvfg_pkg::MV_W-1:0]     stable_reg, stable_base, stable_next;
    logic [bvfg_pkg::MV_W-1:0]     seen_min_reg, seen_max_reg;
    logic [bvfg_pkg::MV_W-1:0]     applied_min_reg, applied_max_reg;
    logic [bvfg_pkg::MV_W-1:0]     seen_min_next, seen_max_next;
    logic [bvfg_pkg::MV_W-1:0]     applied_min_next, applied_max_next;
    logic [bvfg_pkg::STEADY_W-1:0] steady_reg, steady_next;
    logic [bvfg_pkg::TIME_W-1:0]   last_cal_reg, last_cal_next, elapsed;
    logic                          fire, in_lim, grew, shrank, apply;
    bvfg_pkg::trk_t                s3_reg;

    always_comb
    begin
        dec_cnt_next = (dec_cnt_reg == bvfg_pkg::DEC_W'(bvfg_pkg::DECIMATION - 1))
                     ? '0 : dec_cnt_reg + 1'b1;
        fire = (dec_cnt_next == '0);
        held_base = s2.first ? s2.window_mv : held_reg;
        stable_base = s2.first ? s2.window_mv : stable_reg;
        held_next = held_base;
        if (fire && bvfg_pkg::absdiff_mv(s2.ema_mv, held_base) > bvfg_pkg::DEADBAND_MV)
        begin
            held_next = s2.ema_mv;
        end
        stable_next = fire ? held_next : stable_base;

        in_lim = (stable_next >= cfg.cal_low_limit_mv)
              && (stable_next <= cfg.cal_high_limit_mv);
        grew = stable_next > seen_max_reg;
        shrank = stable_next < seen_min_reg;
        seen_max_next = (in_lim && grew) ? stable_next : seen_max_reg;
        seen_min_next = (in_lim && shrank) ? stable_next : seen_min_reg;
        steady_next = steady_reg;
        if (in_lim)
        begin
            if (grew || shrank)
            begin
                steady_next = '0;
            end
            else if (steady_reg != bvfg_pkg::STEADY_MAX)
            begin
                steady_next = steady_reg + 1'b1;
            end
        end
        elapsed = s2.now_ms - last_cal_reg;
        apply = in_lim && !grew && !shrank
             && (steady_next >= cfg.stable_steps_needed)
             && (elapsed > cfg.calibration_interval_ms)
             && ((bvfg_pkg::absdiff_mv(seen_max_reg, applied_max_reg)
                  > bvfg_pkg::CAL_MIN_DELTA_MV)
                 || (bvfg_pkg::absdiff_mv(seen_min_reg, applied_min_reg)
                  > bvfg_pkg::CAL_MIN_DELTA_MV));
        applied_min_next = apply ? seen_min_reg : applied_min_reg;
        applied_max_next = apply ? seen_max_reg : applied_max_reg;
        last_cal_next = apply ? s2.now_ms : last_cal_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dec_cnt_reg     <= '0;
            held_reg        <= '0;
            stable_reg      <= '0;
            steady_reg      <= '0;
            last_cal_reg    <= '0;
            seen_min_reg    <= bvfg_pkg::RST_SAVED_MIN;
            applied_min_reg <= bvfg_pkg::RST_SAVED_MIN;
            seen_max_reg    <= bvfg_pkg::RST_SAVED_MAX;
            applied_max_reg <= bvfg_pkg::RST_SAVED_MAX;
        end
        else
        begin
            if (load)
            begin
                dec_cnt_reg     <= dec_cnt_next;
                held_reg        <= held_next;
                stable_reg      <= stable_next;
                steady_reg      <= steady_next;
                last_cal_reg    <= last_cal_next;
                seen_min_reg    <= seen_min_next;
                seen_max_reg    <= seen_max_next;
                applied_min_reg <= applied_min_next;
                applied_max_reg <= applied_max_next;
            end
            if (cfg_wr.wr_min)
            begin
                seen_min_reg    <= cfg_wr.mv;
                applied_min_reg <= cfg_wr.mv;
            end
            if (cfg_wr.wr_max)
            begin
                seen_max_reg    <= cfg_wr.mv;
                applied_max_reg <= cfg_wr.mv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s3_reg.stable_mv    <= stable_next;
            s3_reg.charging     <= s2.charging;
            s3_reg.window_mv    <= s2.window_mv;
            s3_reg.ema_mv       <= s2.ema_mv;
            s3_reg.range_min_mv <= applied_min_next;
            s3_reg.range_max_mv <= applied_max_next;
            s3_reg.save_request <= apply;
        end
    end

    assign s3 = s3_reg;

endmodule

`default_nettype wire

// ===== src/bvfg_percent.sv =====
// Percent stage: piecewise-linear charge percentage, change flag and the
// result register. Depends on bvfg_pkg.
`default_nettype none

module bvfg_percent (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire bvfg_pkg::trk_t s3,
    output bvfg_pkg::result_t   result
);

    logic [bvfg_pkg::PCT_W-1:0] last_pct_reg, pct;
    logic                       pct_valid_reg, report;
    bvfg_pkg::result_t          result_reg;

    always_comb
    begin
        pct = bvfg_pkg::gauge_pct(s3.stable_mv);
        report = !pct_valid_reg || (pct != last_pct_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pct_reg  <= '0;
            pct_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            last_pct_reg  <= pct;
            pct_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg.stable_mv      <= s3.stable_mv;
            result_reg.percent        <= pct;
            result_reg.charging       <= s3.charging;
            result_reg.report_changed <= report;
            result_reg.window_mv      <= s3.window_mv;
            result_reg.ema_mv         <= s3.ema_mv;
            result_reg.range_min_mv   <= s3.range_min_mv;
            result_reg.range_max_mv   <= s3.range_max_mv;
            result_reg.save_request   <= s3.save_request;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== src/battery_voltage_filter_gauge_core.sv =====
// Battery voltage filter and fuel gauge top level: input register, stage
// control, configuration registers. Depends on bvfg_pkg and all bvfg modules.
// Path: input register, window, EMA, tracker, percent; stages hold and fill
// bubbles independently. Throughput: one item per cycle unless stalled.
// Reset: all filter, tracker and pipeline state clear, saved range loaded.
// Configuration registers reset to their documented defaults.
`default_nettype none

module battery_voltage_filter_gauge_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire bvfg_pkg::sample_t                 sample,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output bvfg_pkg::result_t                      result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bvfg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bvfg_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int NSTG = 5;

    logic [NSTG-1:0]   vld_reg, vld_next, free_s, load_s;
    bvfg_pkg::sample_t s0_reg;
    bvfg_pkg::win_t    s1;
    bvfg_pkg::ema_t    s2;
    bvfg_pkg::trk_t    s3;
    bvfg_pkg::cfg_t    cfg_reg;
    bvfg_pkg::cfg_wr_t cfg_wr;
    logic              cfg_xfer;

    always_comb
    begin
        free_s[NSTG-1] = !vld_reg[NSTG-1] || !result_stall;
        load_s = '0;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            load_s[k+1] = vld_reg[k] && free_s[k+1];
            free_s[k] = !vld_reg[k] || load_s[k+1];
        end
        load_s[0] = sample_valid && free_s[0];
        for (int k = 0; k < NSTG - 1; k++)
        begin
            vld_next[k] = load_s[k] || (vld_reg[k] && !load_s[k+1]);
        end
        vld_next[NSTG-1] = load_s[NSTG-1] || (vld_reg[NSTG-1] && result_stall);
    end

    assign sample_stall = !free_s[0];
    assign result_valid = vld_reg[NSTG-1];
    assign cfg_ready = 1'b1;
    assign cfg_xfer = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s[0])
        begin
            s0_reg <= sample;
        end
    end

    always_comb
    begin
        cfg_wr.wr_min = 1'b0;
        cfg_wr.wr_max = 1'b0;
        cfg_wr.mv = cfg_data[bvfg_pkg::MV_W-1:0];
        case (bvfg_pkg::cfg_idx_t'(cfg_index))
            bvfg_pkg::CFG_SAVED_MIN: cfg_wr.wr_min = cfg_xfer;
            bvfg_pkg::CFG_SAVED_MAX: cfg_wr.wr_max = cfg_xfer;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ema_alpha_q8            <= bvfg_pkg::RST_EMA_ALPHA;
            cfg_reg.max_jump_mv             <= bvfg_pkg::RST_MAX_JUMP;
            cfg_reg.stable_steps_needed     <= bvfg_pkg::RST_STABLE_STEPS;
            cfg_reg.calibration_interval_ms <= bvfg_pkg::RST_CAL_INTERVAL;
            cfg_reg.cal_low_limit_mv        <= bvfg_pkg::RST_CAL_LOW;
            cfg_reg.cal_high_limit_mv       <= bvfg_pkg::RST_CAL_HIGH;
            cfg_reg.saved_min_mv            <= bvfg_pkg::RST_SAVED_MIN;
            cfg_reg.saved_max_mv            <= bvfg_pkg::RST_SAVED_MAX;
        end
        else if (cfg_xfer)
        begin
            case (bvfg_pkg::cfg_idx_t'(cfg_index))
                bvfg_pkg::CFG_EMA_ALPHA:
                    cfg_reg.ema_alpha_q8 <= cfg_data[bvfg_pkg::ALPHA_W-1:0];
                bvfg_pkg::CFG_MAX_JUMP:
                    cfg_reg.max_jump_mv <= cfg_data[bvfg_pkg::JUMP_W-1:0];
                bvfg_pkg::CFG_STABLE_STEPS:
                    cfg_reg.stable_steps_needed <= cfg_data[bvfg_pkg::STEADY_W-1:0];
                bvfg_pkg::CFG_CAL_INTERVAL:
                    cfg_reg.calibration_interval_ms <= cfg_data[bvfg_pkg::TIME_W-1:0];
                bvfg_pkg::CFG_CAL_LOW:
                    cfg_reg.cal_low_limit_mv <= cfg_data[bvfg_pkg::MV_W-1:0];
                bvfg_pkg::CFG_CAL_HIGH:
                    cfg_reg.cal_high_limit_mv <= cfg_data[bvfg_pkg::MV_W-1:0];
                bvfg_pkg::CFG_SAVED_MIN:
                    cfg_reg.saved_min_mv <= cfg_data[bvfg_pkg::MV_W-1:0];
                bvfg_pkg::CFG_SAVED_MAX:
                    cfg_reg.saved_max_mv <= cfg_data[bvfg_pkg::MV_W-1:0];
                default: ;
            endcase
        end
    end

    bvfg_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_s[1]),
        .s0    (s0_reg),
        .s1    (s1)
    );

    bvfg_ema u_ema (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load_s[2]),
        .cfg   (cfg_reg),
        .s1    (s1),
        .s2    (s2)
    );

    bvfg_track u_track (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_s[3]),
        .cfg    (cfg_reg),
        .cfg_wr (cfg_wr),
        .s2     (s2),
        .s3     (s3)
    );

    bvfg_percent u_percent (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_s[4]),
        .s3     (s3),
        .result (result)
    );

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> ((&vld_reg) && result_stall))
        else $error("input stalled while the pipeline has room");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> vld_reg[0])
        else $error("input transfer did not fill the input register");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.percent <= bvfg_pkg::PCT_FULL))
        else $error("percentage above full scale");

endmodule

`default_nettype wire
